/* rtl/core/akv_pkg.sv */
// shared constants, types and control structs of the key/value map
`timescale 1ns / 1ps
`default_nettype none
package akv_pkg;

  // table geometry
  localparam int unsigned Capacity  = 1024;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned IdxW      = $clog2(Capacity);
  localparam int unsigned CntW      = $clog2(Capacity + 1);

  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [ValueBits-1:0] value_t;

  // command codes
  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_ERASE = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_SLOT,
    S_CAPTURE,
    S_RD_LAST,
    S_MOVE,
    S_RESP
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic scan;
    logic rd_slot;
    logic rd_last;
    logic capture;
    logic write_hit;
    logic move;
    logic insert;
    logic clear;
    logic set_full;
    logic set_nf;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       hit;
    logic       miss;
    logic       full;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/core/akv_ram.sv */
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module akv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/akv_ctrl.sv */
// command sequencer of the key/value map
`timescale 1ns / 1ps
`default_nettype none
module akv_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  output logic                done_o,
  input  wire akv_pkg::stat_t stat_i,
  output akv_pkg::ctrl_t      ctrl_o
);

  akv_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= akv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      akv_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = akv_pkg::S_SCAN;
        end
      end
      akv_pkg::S_SCAN: begin
        unique case (stat_i.cmd)
          akv_pkg::CMD_READ, akv_pkg::CMD_WRITE: begin
            ctrl_o.scan = 1'b1;
            if (stat_i.hit) begin
              state_d = akv_pkg::S_RD_SLOT;
            end else if (stat_i.miss) begin
              if (stat_i.full) begin
                ctrl_o.set_full = 1'b1;
              end else begin
                ctrl_o.insert = 1'b1;
              end
              state_d = akv_pkg::S_RESP;
            end
          end
          akv_pkg::CMD_PEEK: begin
            ctrl_o.scan = 1'b1;
            if (stat_i.hit) begin
              state_d = akv_pkg::S_RD_SLOT;
            end else if (stat_i.miss) begin
              state_d = akv_pkg::S_RESP;
            end
          end
          akv_pkg::CMD_ERASE: begin
            ctrl_o.scan = 1'b1;
            if (stat_i.hit) begin
              state_d = akv_pkg::S_RD_SLOT;
            end else if (stat_i.miss) begin
              ctrl_o.set_nf = 1'b1;
              state_d       = akv_pkg::S_RESP;
            end
          end
          akv_pkg::CMD_CLEAR: begin
            ctrl_o.clear = 1'b1;
            state_d      = akv_pkg::S_RESP;
          end
          default: begin
            state_d = akv_pkg::S_RESP;
          end
        endcase
      end
      akv_pkg::S_RD_SLOT: begin
        ctrl_o.rd_slot = 1'b1;
        if (stat_i.cmd == akv_pkg::CMD_ERASE) begin
          state_d = akv_pkg::S_RD_LAST;
        end else begin
          state_d = akv_pkg::S_CAPTURE;
        end
      end
      akv_pkg::S_CAPTURE: begin
        ctrl_o.capture   = 1'b1;
        ctrl_o.write_hit = (stat_i.cmd == akv_pkg::CMD_WRITE);
        state_d          = akv_pkg::S_RESP;
      end
      akv_pkg::S_RD_LAST: begin
        ctrl_o.capture = 1'b1;
        ctrl_o.rd_last = 1'b1;
        state_d        = akv_pkg::S_MOVE;
      end
      akv_pkg::S_MOVE: begin
        ctrl_o.move = 1'b1;
        state_d     = akv_pkg::S_RESP;
      end
      akv_pkg::S_RESP: begin
        done_o  = 1'b1;
        state_d = akv_pkg::S_IDLE;
      end
      default: begin
        state_d = akv_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/akv_datapath.sv */
// key and value memories, search pipeline and result registers
`timescale 1ns / 1ps
`default_nettype none
module akv_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     cmd_i,
  input  wire logic [31:0]    key_i,
  input  wire logic [31:0]    write_value_i,
  input  wire akv_pkg::ctrl_t ctrl_i,
  output akv_pkg::stat_t      stat_o,
  output logic [31:0]         read_value_o,
  output logic                found_o,
  output logic [1:0]          status_o,
  output logic [10:0]         entry_count_o
);

  logic [2:0]       cmd_q;
  akv_pkg::key_t    key_q;
  akv_pkg::value_t  val_q;
  akv_pkg::cnt_t    count_q;
  akv_pkg::cnt_t    scan_q;
  logic             pipe_vld_q;
  akv_pkg::idx_t    pipe_idx_q;
  akv_pkg::idx_t    slot_q;
  akv_pkg::value_t  rv_q;
  logic             found_q;
  akv_pkg::status_e status_q;

  akv_pkg::key_t   key_rdata;
  akv_pkg::value_t val_rdata;
  akv_pkg::cnt_t   last_cnt;
  akv_pkg::idx_t   last_idx;
  akv_pkg::idx_t   cnt_idx;
  logic            issue;
  logic            hit;

  logic            key_we, key_re, val_we, val_re;
  akv_pkg::idx_t   key_waddr, key_raddr, val_waddr, val_raddr;
  akv_pkg::key_t   key_wdata;
  akv_pkg::value_t val_wdata;

  assign last_cnt = count_q - akv_pkg::cnt_t'(1);
  assign last_idx = last_cnt[akv_pkg::IdxW-1:0];
  assign cnt_idx  = count_q[akv_pkg::IdxW-1:0];

  // search: one key read issued per cycle, compared in the following cycle
  assign issue = ctrl_i.scan && (scan_q != count_q);
  assign hit   = pipe_vld_q && (key_rdata == key_q);

  assign stat_o.cmd  = cmd_q;
  assign stat_o.hit  = hit;
  assign stat_o.miss = (scan_q == count_q) && !hit;
  assign stat_o.full = (count_q == akv_pkg::cnt_t'(akv_pkg::Capacity));

  // key memory ports
  assign key_re    = issue || ctrl_i.rd_last;
  assign key_raddr = ctrl_i.rd_last ? last_idx : scan_q[akv_pkg::IdxW-1:0];
  assign key_we    = ctrl_i.insert || ctrl_i.move;
  assign key_waddr = ctrl_i.insert ? cnt_idx : slot_q;
  assign key_wdata = ctrl_i.insert ? key_q : key_rdata;

  // value memory ports
  assign val_re    = ctrl_i.rd_slot || ctrl_i.rd_last;
  assign val_raddr = ctrl_i.rd_last ? last_idx : slot_q;
  assign val_we    = ctrl_i.insert || ctrl_i.write_hit || ctrl_i.move;
  assign val_waddr = ctrl_i.insert ? cnt_idx : slot_q;

  always_comb begin
    if (ctrl_i.move) begin
      val_wdata = val_rdata;
    end else if (ctrl_i.insert && (cmd_q != akv_pkg::CMD_WRITE)) begin
      val_wdata = '0;
    end else begin
      val_wdata = val_q;
    end
  end

  akv_ram #(
    .Width(akv_pkg::KeyBits),
    .Depth(akv_pkg::Capacity)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (key_re),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  akv_ram #(
    .Width(akv_pkg::ValueBits),
    .Depth(akv_pkg::Capacity)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .re_i   (val_re),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  // entry count and search counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_q     <= '0;
      pipe_vld_q <= 1'b0;
    end else begin
      pipe_vld_q <= issue;
      if (ctrl_i.latch) begin
        scan_q <= '0;
      end else if (issue) begin
        scan_q <= scan_q + akv_pkg::cnt_t'(1);
      end
      if (ctrl_i.clear) begin
        count_q <= '0;
      end else if (ctrl_i.insert) begin
        count_q <= count_q + akv_pkg::cnt_t'(1);
      end else if (ctrl_i.move) begin
        count_q <= last_cnt;
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      pipe_idx_q <= scan_q[akv_pkg::IdxW-1:0];
    end
    if (ctrl_i.scan && hit) begin
      slot_q <= pipe_idx_q;
    end
    if (ctrl_i.latch) begin
      cmd_q    <= cmd_i;
      key_q    <= key_i[akv_pkg::KeyBits-1:0];
      val_q    <= write_value_i[akv_pkg::ValueBits-1:0];
      rv_q     <= '0;
      found_q  <= 1'b0;
      status_q <= akv_pkg::ST_OK;
    end else begin
      if (ctrl_i.capture) begin
        rv_q    <= val_rdata;
        found_q <= 1'b1;
      end
      if (ctrl_i.set_full) begin
        status_q <= akv_pkg::ST_FULL;
      end else if (ctrl_i.set_nf) begin
        status_q <= akv_pkg::ST_NOT_FOUND;
      end
    end
  end

  assign read_value_o  = 32'(rv_q);
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = 11'(count_q);

endmodule
`default_nettype wire

/* rtl/core/array_key_value_map.sv */
// unsorted key/value map with linear search: top level
//
// channel   direction  signals                                            transfer
// request   in         start_i, busy_o, cmd_i, key_i, write_value_i      start_i && !busy_o
// result    out        done_o, read_value_o, found_o, status_o,           done_o (one cycle)
//                      entry_count_o
//
// the search compares one stored key per cycle through the key memory read port.
// done_o rises in the last busy cycle; the receiver cannot stall the result.
// after reset the table is empty and the block is idle at once.
`timescale 1ns / 1ps
`default_nettype none
module array_key_value_map (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] write_value_i,
  output logic             done_o,
  output logic [31:0]      read_value_o,
  output logic             found_o,
  output logic [1:0]       status_o,
  output logic [10:0]      entry_count_o
);

  akv_pkg::ctrl_t ctrl;
  akv_pkg::stat_t stat;

  // sequencer
  akv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // memories and result registers
  akv_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .write_value_i(write_value_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .read_value_o (read_value_o),
    .found_o      (found_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  // an accepted request keeps the block busy until its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("request accepted but block not busy");

  // after a result the block is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block still busy after result transfer");

  // a refused insert only happens with a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == akv_pkg::ST_FULL)) |->
      (entry_count_o == 11'(akv_pkg::Capacity)) && !found_o)
    else $error("full status with room left");

  // a found key never carries an error status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == akv_pkg::ST_OK))
    else $error("found key reported with error status");

  // entry count stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= 11'(akv_pkg::Capacity))
    else $error("entry count beyond capacity");

endmodule
`default_nettype wire

/* tb/sv/array_key_value_map_test.sv */
// self-checking testbench for the linear-search key/value map
`timescale 1ns / 1ps
module array_key_value_map_test;
  import akv_pkg::*;

  localparam int unsigned ClockPeriod = 20;
  localparam longint unsigned TimeoutNs = 64'd200_000_000;
  localparam int unsigned DrainLimit = 4 * (Capacity + 8);
  // codes outside the command set, treated as no operation
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  typedef struct {
    value_t  read_value;
    logic    found;
    status_e status;
    cnt_t    entry_count;
  } map_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  cmd_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] write_value_i = '0;
  logic        done_o;
  logic [31:0] read_value_o;
  logic        found_o;
  logic [1:0]  status_o;
  logic [10:0] entry_count_o;

  // shadow copy of the map contents
  key_t        shadow_keys [Capacity];
  value_t      shadow_values [Capacity];
  int unsigned shadow_count = 0;

  map_result_t expected_results[$];
  int unsigned sender_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned command_count = 0;
  int unsigned hit_count = 0;
  int unsigned full_count = 0;
  int unsigned absent_erase_count = 0;
  longint unsigned cycle_count = 0;

  array_key_value_map DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .write_value_i (write_value_i),
    .done_o        (done_o),
    .read_value_o  (read_value_o),
    .found_o       (found_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  // clock
  always #(ClockPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
  end

  // apply one command to the shadow map and work out its result
  function automatic map_result_t predict_command(input logic [2:0] op, input key_t k,
                                                  input value_t v);
    map_result_t r;
    int unsigned slot;
    int unsigned i;
    bit hit;
    r = '{read_value: '0, found: 1'b0, status: ST_OK, entry_count: '0};
    hit = 1'b0;
    slot = 0;
    for (i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_keys[i] == k) begin
        hit = 1'b1;
        slot = i;
      end
    end
    case (op)
      CMD_READ, CMD_WRITE: begin
        if (hit) begin
          r.read_value = shadow_values[slot];
          r.found = 1'b1;
        end else if (shadow_count < Capacity) begin
          slot = shadow_count;
          shadow_keys[slot] = k;
          shadow_values[slot] = '0;
          shadow_count++;
        end else begin
          r.status = ST_FULL;
        end
        if (op == CMD_WRITE && r.status == ST_OK) shadow_values[slot] = v;
      end
      CMD_PEEK: begin
        if (hit) begin
          r.read_value = shadow_values[slot];
          r.found = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (hit) begin
          r.read_value = shadow_values[slot];
          r.found = 1'b1;
          // last entry fills the freed slot
          shadow_keys[slot] = shadow_keys[shadow_count - 1];
          shadow_values[slot] = shadow_values[shadow_count - 1];
          shadow_count--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.entry_count = cnt_t'(shadow_count);
    command_count++;
    if (r.found) hit_count++;
    if (r.status == ST_FULL) full_count++;
    if (r.status == ST_NOT_FOUND) absent_erase_count++;
    return r;
  endfunction

  // send one command, wait for its transfer and record the expected result
  task automatic send_command(input logic [2:0] op, input key_t k, input value_t v);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    cmd_i         <= op;
    key_i         <= k;
    write_value_i <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_results.push_back(predict_command(op, k, v));
  endtask

  // result checker
  always @(posedge clk_i) begin
    map_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: value %h found %b status %0d count %0d",
                 $time, read_value_o, found_o, status_o, entry_count_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (read_value_o !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   read_value_o);
          error_count++;
        end
        if (found_o !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, found_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          error_count++;
        end
        if (entry_count_o !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   entry_count_o);
          error_count++;
        end
      end
    end
  end

  // read, write and peek on a small map, with extreme keys and values
  task automatic test_basic_commands();
    sender_idle_pct = 0;
    send_command(CMD_PEEK, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(CMD_READ, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(CMD_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(CMD_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_command(CMD_READ, 32'hFFFF_FFFF, 32'h1234_5678);
    send_command(CMD_WRITE, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    send_command(CMD_PEEK, 32'h0000_0000, 32'h0000_0000);
    send_command(CMD_WRITE, 32'h8000_0000, 32'h0000_0001);
  endtask

  // erase of the first entry moves the last one, then erase down to empty
  task automatic test_erase_and_move();
    sender_idle_pct = 0;
    send_command(CMD_ERASE, 32'h0000_0000, 32'h0000_0000);
    send_command(CMD_PEEK, 32'h8000_0000, 32'h0000_0000);
    send_command(CMD_ERASE, 32'h1234_5678, 32'hFFFF_FFFF);
    send_command(CMD_ERASE, 32'h8000_0000, 32'h0000_0000);
    send_command(CMD_ERASE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_command(CMD_ERASE, 32'hA5A5_5A5A, 32'h0000_0000);
    send_command(CMD_ERASE, 32'hA5A5_5A5A, 32'h0000_0000);
  endtask

  // unknown codes leave the map alone, clear empties it
  task automatic test_unknown_and_clear();
    int unsigned code;
    sender_idle_pct = 0;
    send_command(CMD_WRITE, 32'h0F0F_F0F0, 32'hC3C3_3C3C);
    for (code = 32'(CMD_UNUSED_FIRST); code <= 32'(CMD_UNUSED_LAST); code++)
      send_command(3'(code), 32'h0F0F_F0F0, 32'hFFFF_FFFF);
    send_command(CMD_CLEAR, 32'h0F0F_F0F0, 32'h0000_0000);
    send_command(CMD_PEEK, 32'h0F0F_F0F0, 32'h0000_0000);
  endtask

  // fill every slot, then refused inserts, hits and erases on a full map
  task automatic test_full_table();
    int unsigned i;
    sender_idle_pct = 0;
    send_command(CMD_CLEAR, '0, '0);
    for (i = 0; i < Capacity; i++)
      send_command(CMD_WRITE, key_t'(i * 32'h9E37_79B9 + 32'h1357_9BDF), $urandom);
    send_command(CMD_READ, key_t'(Capacity * 32'h9E37_79B9 + 32'h1357_9BDF), $urandom);
    send_command(CMD_WRITE, key_t'(Capacity * 32'h9E37_79B9 + 32'h1357_9BDF), $urandom);
    send_command(CMD_PEEK, key_t'(Capacity * 32'h9E37_79B9 + 32'h1357_9BDF), $urandom);
    send_command(CMD_WRITE, key_t'((Capacity - 1) * 32'h9E37_79B9 + 32'h1357_9BDF),
                 32'hFFFF_FFFF);
    send_command(CMD_ERASE, key_t'(32'h1357_9BDF), $urandom);
    send_command(CMD_PEEK, key_t'((Capacity - 1) * 32'h9E37_79B9 + 32'h1357_9BDF), '0);
    send_command(CMD_WRITE, key_t'(Capacity * 32'h9E37_79B9 + 32'h1357_9BDF), $urandom);
    send_command(CMD_READ, key_t'((Capacity + 1) * 32'h9E37_79B9 + 32'h1357_9BDF), '0);
    send_command(CMD_ERASE, key_t'((Capacity + 2) * 32'h9E37_79B9 + 32'h1357_9BDF), '0);
    send_command(CMD_CLEAR, '0, '0);
  endtask

  // random commands on keys drawn mostly from a small pool so that hits are common
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned n_items);
    key_t        pool [16];
    int unsigned pick;
    logic [2:0]  op;
    key_t        k;
    value_t      v;
    sender_idle_pct = idle_pct;
    foreach (pool[i]) pool[i] = $urandom;
    repeat (n_items) begin
      pick = $urandom_range(99, 0);
      if (pick < 22) op = CMD_READ;
      else if (pick < 52) op = CMD_WRITE;
      else if (pick < 67) op = CMD_PEEK;
      else if (pick < 90) op = CMD_ERASE;
      else if (pick < 94) op = CMD_CLEAR;
      else op = 3'($urandom_range(32'(CMD_UNUSED_LAST), 32'(CMD_UNUSED_FIRST)));
      k = ($urandom_range(9, 0) < 7) ? pool[$urandom_range(15, 0)] : key_t'($urandom);
      pick = $urandom_range(9, 0);
      if (pick == 0) v = '0;
      else if (pick == 1) v = '1;
      else v = $urandom;
      send_command(op, k, v);
    end
  endtask

  // run limit
  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

  // test sequence
  initial begin
    int unsigned guard;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_commands();
    test_erase_and_move();
    test_unknown_and_clear();
    test_full_table();
    test_random_traffic(0, 200);
    test_random_traffic(72, 190);
    test_random_traffic(11, 190);
    start_i <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Capacity + 8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    $display("covered %0d commands in %0d cycles, map filled to %0d entries once",
             command_count, cycle_count, Capacity);
    $display("%0d hits, %0d inserts refused when full, %0d erases of absent keys",
             hit_count, full_count, absent_erase_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
